@@ sv/pli_pkg.sv @@
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants of the piecewise linear interpolator
// Field widths, stream packing sizes, action codes and the request/response
// structs passed between the controller and the serial multiply/divide unit.
// ----------------------------------------------------------------------------
package pli_pkg;

  // field widths
  localparam int unsigned XW   = 16;  // breakpoint / query x, unsigned
  localparam int unsigned YW   = 16;  // breakpoint y and result, signed
  localparam int unsigned IDX_W = 4;  // entry index and segment
  localparam int unsigned PC_W = 5;   // point count register

  localparam int unsigned MAX_POINTS_DEF = 16;

  localparam logic [PC_W-1:0] PC_RESET   = PC_W'(2);
  localparam logic [PC_W-1:0] MIN_POINTS = PC_W'(2);

  // product of |dy| and |dx|, also the quotient width
  localparam int unsigned PROD_W = XW + YW;

  // stream data widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = ((IDX_W + XW + YW + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((YW + IDX_W + 7) / 8) * 8;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_e;

  // request to the serial multiply/divide unit: (mcand * mplier) / divisor
  typedef struct packed {
    logic          start;
    logic [YW-1:0] mcand;
    logic [XW-1:0] mplier;
    logic [XW-1:0] divisor;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
  } md_rsp_t;

endpackage

@@ sv/pli_table.sv @@
// ----------------------------------------------------------------------------
// pli_table: breakpoint store
// One write port and one read port with registered read data; each entry
// holds a breakpoint x and its y.
// ----------------------------------------------------------------------------
module pli_table import pli_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  localparam int unsigned AW = $clog2(MAX_POINTS)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [XW-1:0] wx_i,
  input  logic [YW-1:0] wy_i,
  input  logic [AW-1:0] raddr_i,
  output logic [XW-1:0] rx_o,
  output logic [YW-1:0] ry_o
);

  logic [XW+YW-1:0] mem_q [MAX_POINTS];
  logic [XW+YW-1:0] rd_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wy_i, wx_i};
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[raddr_i];
  end

  assign rx_o = rd_q[XW-1:0];
  assign ry_o = rd_q[XW+YW-1:XW];

endmodule

@@ sv/pli_muldiv.sv @@
// ----------------------------------------------------------------------------
// pli_muldiv: bit-serial multiply then divide
// Shift-and-add multiply, one multiplier bit per cycle, followed by a
// restoring divide, one quotient bit per cycle, in the same shift register.
// ----------------------------------------------------------------------------
module pli_muldiv import pli_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(PROD_W);

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

  md_state_e         state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [YW-1:0]     mcand_q, mcand_d;
  logic [XW-1:0]     dvsr_q, dvsr_d;
  logic [XW-1:0]     rem_q, rem_d;
  logic              done_q, done_d;

  logic [YW:0]       psum;
  logic [XW:0]       rshift;
  logic [XW:0]       trial;

  // one multiply step and one divide step
  always_comb begin
    psum   = {1'b0, acc_q[PROD_W-1:XW]} + (acc_q[0] ? {1'b0, mcand_q} : '0);
    rshift = {rem_q, acc_q[PROD_W-1]};
    trial  = rshift - {1'b0, dvsr_q};
  end

  // sequencing
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    mcand_d = mcand_q;
    dvsr_d  = dvsr_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          acc_d   = {{YW{1'b0}}, req_i.mplier};
          mcand_d = req_i.mcand;
          dvsr_d  = req_i.divisor;
          cnt_d   = CNT_W'(XW - 1);
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        acc_d = {psum, acc_q[XW-1:1]};
        if (cnt_q == '0) begin
          cnt_d   = CNT_W'(PROD_W - 1);
          rem_d   = '0;
          state_d = MD_DIV;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      MD_DIV: begin
        // borrow clear: partial remainder covers the divisor
        if (!trial[XW]) begin
          rem_d = trial[XW-1:0];
          acc_d = {acc_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_d = rshift[XW-1:0];
          acc_d = {acc_q[PROD_W-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = MD_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    dvsr_q  <= dvsr_d;
    rem_q   <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q;

endmodule

@@ sv/piecewise_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator: breakpoint table with linear interpolation
// Loads breakpoints by write transfers and answers query transfers with the
// interpolated or extrapolated y of the segment that holds the query x.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: s_tuser_i selects write (0) or query (1). A write transfer
//   stores sample_x/sample_y at entry_index and gives no result.
//   A query transfer gives exactly one result on the output stream.
//   cfg_we_i/cfg_wdata_i set the number of breakpoints in use (2 after
//   reset); write it only while no query is in flight.
//   A query, from input transfer to result offered, scans the breakpoints
//   one at a time (segment index + 1 of them; only the first for a query at
//   or below the first point), makes two table reads, then runs the
//   bit-serial multiply and the restoring divide in the serial multiply/
//   divide unit, and ends in control and output. A segment whose x
//   endpoints are equal skips the arithmetic. The next transfer can be
//   taken in the same cycle in which the result is first offered.
//   One query is worked on at a time; s_tready_o is high whenever the block
//   is free, also while a finished result still waits in the output register.
//   When the receiver stalls, the result holds in that register and a second
//   finished result waits inside until it drains.
//   Reset clears the control state and sets the point count to 2; table
//   contents are undefined until written.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator import pli_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF  // 2 .. 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration: point count
  input  logic                  cfg_we_i,
  input  logic [PC_W-1:0]       cfg_wdata_i,
  // input stream
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,   // entry_index, sample_x, sample_y
  input  logic [0:0]            s_tuser_i,   // action
  // output stream
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,   // value, segment
  output logic [1:0]            m_tuser_o    // saturated, zero_span
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned SW = PROD_W + 2;
  localparam logic [PC_W-1:0] N_MAX = PC_W'(MAX_POINTS);
  localparam logic signed [SW-1:0] Y_MAX_EXT =
    $signed({{(SW-YW){1'b0}}, 1'b0, {(YW-1){1'b1}}});
  localparam logic signed [SW-1:0] Y_MIN_EXT =
    $signed({{(SW-YW){1'b1}}, 1'b1, {(YW-1){1'b0}}});

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_HI,
    ST_RD_LO,
    ST_WAIT,
    ST_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic [AW-1:0]     hi_q, hi_d;
  logic [XW-1:0]     x_q, x_d;
  logic [XW-1:0]     xh_q, xh_d;
  logic [YW-1:0]     yh_q, yh_d;
  logic [YW-1:0]     yl_q, yl_d;
  logic              neg_q, neg_d;
  logic [YW-1:0]     res_q, res_d;
  logic              sat_q, sat_d;
  logic              zspan_q, zspan_d;
  logic              m_valid_q, m_valid_d;
  logic [YW-1:0]     m_value_q, m_value_d;
  logic [IDX_W-1:0]  m_seg_q, m_seg_d;
  logic              m_sat_q, m_sat_d;
  logic              m_zspan_q, m_zspan_d;

  // input fields
  action_e           in_action;
  logic [IDX_W-1:0]  in_idx;
  logic [XW-1:0]     in_x;
  logic [YW-1:0]     in_y;
  logic              in_xfer;

  // table ports
  logic              tbl_we;
  logic [AW-1:0]     tbl_raddr;
  logic [XW-1:0]     rd_x;
  logic [YW-1:0]     rd_y;

  // scan and segment arithmetic
  logic [PC_W-1:0]   n_eff;
  logic              advance;
  logic [AW-1:0]     hi_fix;
  logic [XW:0]       dx, span, ndx, nspan;
  logic [YW:0]       dy, ndy;
  logic              out_free;
  logic signed [SW-1:0] yl_ext, q_ext, sum;

  md_req_t           md_req;
  md_rsp_t           md_rsp;

  assign in_action = action_e'(s_tuser_i[0]);
  assign in_idx    = s_tdata_i[IDX_W-1:0];
  assign in_x      = s_tdata_i[IDX_W +: XW];
  assign in_y      = s_tdata_i[IDX_W+XW +: YW];

  assign s_tready_o = (state_q == ST_IDLE);
  assign in_xfer    = s_tvalid_i && s_tready_o;
  assign tbl_we     = in_xfer && (in_action == ACT_WRITE) && ({1'b0, in_idx} < N_MAX);

  pli_table #(
    .MAX_POINTS (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (in_idx[AW-1:0]),
    .wx_i    (in_x),
    .wy_i    (in_y),
    .raddr_i (tbl_raddr),
    .rx_o    (rd_x),
    .ry_o    (rd_y)
  );

  pli_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // point count clamped to the range MIN_POINTS .. table size
  always_comb begin
    if (pc_q < MIN_POINTS) begin
      n_eff = MIN_POINTS;
    end else if (pc_q > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = pc_q;
    end
  end

  // scan step: rd holds entry hi_q while in the scan state
  assign advance = ((PC_W'(hi_q) + PC_W'(1)) < n_eff) && (x_q > rd_x);
  assign hi_fix  = (hi_q == '0) ? AW'(1) : hi_q;

  // segment differences; rd holds the lower breakpoint in ST_RD_LO
  always_comb begin
    dx    = {1'b0, x_q} - {1'b0, rd_x};
    span  = {1'b0, xh_q} - {1'b0, rd_x};
    dy    = {yh_q[YW-1], yh_q} - {rd_y[YW-1], rd_y};
    ndx   = -dx;
    nspan = -span;
    ndy   = -dy;
  end

  // signed result of the quotient, before saturation
  always_comb begin
    yl_ext = $signed({{(SW-YW){yl_q[YW-1]}}, yl_q});
    q_ext  = $signed({2'b00, md_rsp.quot});
    sum    = neg_q ? (yl_ext - q_ext) : (yl_ext + q_ext);
  end

  assign out_free = !m_valid_q || m_tready_i;

  // control and datapath next state
  always_comb begin
    state_d   = state_q;
    pc_d      = cfg_we_i ? cfg_wdata_i : pc_q;
    hi_d      = hi_q;
    x_d       = x_q;
    xh_d      = xh_q;
    yh_d      = yh_q;
    yl_d      = yl_q;
    neg_d     = neg_q;
    res_d     = res_q;
    sat_d     = sat_q;
    zspan_d   = zspan_q;
    m_valid_d = m_valid_q && !m_tready_i;
    m_value_d = m_value_q;
    m_seg_d   = m_seg_q;
    m_sat_d   = m_sat_q;
    m_zspan_d = m_zspan_q;
    tbl_raddr = hi_q;
    md_req    = '0;
    case (state_q)
      ST_IDLE: begin
        tbl_raddr = '0;
        if (in_xfer && (in_action == ACT_EVAL)) begin
          x_d     = in_x;
          hi_d    = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (advance) begin
          hi_d      = hi_q + 1'b1;
          tbl_raddr = hi_q + 1'b1;
        end else begin
          hi_d      = hi_fix;
          tbl_raddr = hi_fix;
          state_d   = ST_RD_HI;
        end
      end
      ST_RD_HI: begin
        xh_d      = rd_x;
        yh_d      = rd_y;
        tbl_raddr = hi_q - 1'b1;
        state_d   = ST_RD_LO;
      end
      ST_RD_LO: begin
        yl_d = rd_y;
        if (span == '0) begin
          // equal x endpoints: y_low, no arithmetic
          res_d   = rd_y;
          sat_d   = 1'b0;
          zspan_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          md_req.start   = 1'b1;
          md_req.mcand   = dy[YW] ? ndy[YW-1:0] : dy[YW-1:0];
          md_req.mplier  = dx[XW] ? ndx[XW-1:0] : dx[XW-1:0];
          md_req.divisor = span[XW] ? nspan[XW-1:0] : span[XW-1:0];
          neg_d          = dx[XW] ^ dy[YW] ^ span[XW];
          zspan_d        = 1'b0;
          state_d        = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (md_rsp.done) begin
          if (sum > Y_MAX_EXT) begin
            res_d = Y_MAX_EXT[YW-1:0];
            sat_d = 1'b1;
          end else if (sum < Y_MIN_EXT) begin
            res_d = Y_MIN_EXT[YW-1:0];
            sat_d = 1'b1;
          end else begin
            res_d = sum[YW-1:0];
            sat_d = 1'b0;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_value_d = res_q;
          m_seg_d   = IDX_W'(hi_q);
          m_sat_d   = sat_q;
          m_zspan_d = zspan_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state, point count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= PC_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hi_q      <= hi_d;
    x_q       <= x_d;
    xh_q      <= xh_d;
    yh_q      <= yh_d;
    yl_q      <= yl_d;
    neg_q     <= neg_d;
    res_q     <= res_d;
    sat_q     <= sat_d;
    zspan_q   <= zspan_d;
    m_value_q <= m_value_d;
    m_seg_q   <= m_seg_d;
    m_sat_q   <= m_sat_d;
    m_zspan_q <= m_zspan_d;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = OUT_DATA_W'({m_seg_q, m_value_q});
  assign m_tuser_o  = {m_zspan_q, m_sat_q};

endmodule

@@ sv/pli_checker.sv @@
// ----------------------------------------------------------------------------
// pli_checker: port-level checks of the piecewise linear interpolator
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pli_checker import pli_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_tvalid_i,
  input logic                  s_tready_o,
  input logic [0:0]            s_tuser_i,
  input logic                  m_tvalid_o,
  input logic                  m_tready_i,
  input logic [OUT_DATA_W-1:0] m_tdata_o,
  input logic [1:0]            m_tuser_o
);

  localparam logic [YW-1:0] Y_MAX = {1'b0, {(YW-1){1'b1}}};
  localparam logic [YW-1:0] Y_MIN = {1'b1, {(YW-1){1'b0}}};

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("result dropped while stalled");

  // a query transfer makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o && (s_tuser_i[0] == ACT_EVAL) |=> !s_tready_o)
    else $error("ready after query transfer");

  // a table write leaves the block free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o && (s_tuser_i[0] == ACT_WRITE) |=> s_tready_o)
    else $error("busy after table write");

  // segment index is always at least one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[YW +: IDX_W] != '0))
    else $error("segment zero reported");

  // a saturated result sits at a range limit and is not a zero span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[0] |->
      !m_tuser_o[1] && ((m_tdata_o[YW-1:0] == Y_MAX) || (m_tdata_o[YW-1:0] == Y_MIN)))
    else $error("saturation flag without a limit value");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .s_tuser_i  (s_tuser_i),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);
